### src/ddo_pkg.sv
// Shared types, codes and constant tables for the wheel odometry block.
package ddo_pkg;

    typedef logic [3:0] mul_op_t;

    localparam mul_op_t MOP_CM    = 4'd0;
    localparam mul_op_t MOP_P     = 4'd1;
    localparam mul_op_t MOP_RM    = 4'd2;
    localparam mul_op_t MOP_BAM   = 4'd3;
    localparam mul_op_t MOP_VLIN  = 4'd4;
    localparam mul_op_t MOP_VTURN = 4'd5;
    localparam mul_op_t MOP_X     = 4'd6;
    localparam mul_op_t MOP_Y     = 4'd7;
    localparam mul_op_t MOP_WL    = 4'd8;
    localparam mul_op_t MOP_WR    = 4'd9;

    typedef struct packed {
        logic    take;
        logic    latch;
        logic    mul_start;
        mul_op_t mul_op;
        logic    cor_start;
        logic    cor_quat;
        logic    div_start;
        logic    div_turn;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic mul_busy;
        logic mul_done;
        logic cor_busy;
        logic cor_done;
        logic div_busy;
    } sts_t;

    localparam logic [1:0] CFG_METERS    = 2'd0;
    localparam logic [1:0] CFG_RADIANS   = 2'd1;
    localparam logic [1:0] CFG_INV_TRACK = 2'd2;

    localparam logic [31:0] METERS_RESET    = 32'd1839958;
    localparam logic [31:0] RADIANS_RESET   = 32'd40888002;
    localparam logic [31:0] INV_TRACK_RESET = 32'd55924053;

    localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

    localparam logic signed [47:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] POS_MIN = 48'sh8000_0000_0000;

    localparam int ATAN_IW = 5;

    // Arctangent of 2^-i as a binary angle (full turn = 2^32).
    function automatic logic [31:0] atan_bam(input logic [ATAN_IW-1:0] i);
        logic [31:0] v;
        begin
            unique case (i)
                5'd0:  v = 32'd536870912;
                5'd1:  v = 32'd316933406;
                5'd2:  v = 32'd167458907;
                5'd3:  v = 32'd85004756;
                5'd4:  v = 32'd42667331;
                5'd5:  v = 32'd21354465;
                5'd6:  v = 32'd10679838;
                5'd7:  v = 32'd5340245;
                5'd8:  v = 32'd2670163;
                5'd9:  v = 32'd1335087;
                5'd10: v = 32'd667544;
                5'd11: v = 32'd333772;
                5'd12: v = 32'd166886;
                5'd13: v = 32'd83443;
                5'd14: v = 32'd41722;
                5'd15: v = 32'd20861;
                5'd16: v = 32'd10430;
                5'd17: v = 32'd5215;
                5'd18: v = 32'd2608;
                5'd19: v = 32'd1304;
                5'd20: v = 32'd652;
                5'd21: v = 32'd326;
                5'd22: v = 32'd163;
                5'd23: v = 32'd81;
                5'd24: v = 32'd41;
                5'd25: v = 32'd20;
                5'd26: v = 32'd10;
                5'd27: v = 32'd5;
                5'd28: v = 32'd3;
                5'd29: v = 32'd1;
                5'd30: v = 32'd1;
                5'd31: v = 32'd0;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

    // Adds a signed step to a position; the step is clamped to 2^48 and the sum
    // to the 48-bit signed range.
    function automatic logic signed [47:0] add_pos(input logic signed [47:0] base,
                                                   input logic [63:0] m,
                                                   input logic neg);
        logic [48:0] mc;
        logic signed [50:0] d;
        logic signed [50:0] r;
        logic signed [47:0] res;
        begin
            mc = (m > 64'h0001_0000_0000_0000) ? 49'h1_0000_0000_0000 : m[48:0];
            d = neg ? -$signed({2'b00, mc}) : $signed({2'b00, mc});
            r = $signed({{3{base[47]}}, base}) + d;
            if (r > 51'sd140737488355327) begin
                res = POS_MAX;
            end else if (r < -51'sd140737488355328) begin
                res = POS_MIN;
            end else begin
                res = r[47:0];
            end
            return res;
        end
    endfunction

endpackage

### src/ddo_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle.
module ddo_cordic #(
    parameter int STEPS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic               busy,
    output logic               done,
    output logic signed [31:0] cos_val,
    output logic signed [31:0] sin_val
);
    import ddo_pkg::*;

    localparam int SW = $clog2(STEPS);

    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [SW-1:0]      step_reg, step_next;
    logic               flip_reg, flip_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [33:0] z_reg, z_next;

    logic               fold;
    logic [31:0]        folded;
    logic signed [33:0] dx, dy, at;
    logic signed [33:0] xf, yf;
    logic               last;

    assign fold   = (angle > 32'h4000_0000) && (angle < 32'hC000_0000);
    assign folded = fold ? angle + 32'h8000_0000 : angle;
    assign dx     = y_reg >>> step_reg;
    assign dy     = x_reg >>> step_reg;
    assign at     = $signed({2'b00, atan_bam(ATAN_IW'(step_reg))});
    assign last   = (step_reg == SW'(STEPS - 1));

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        flip_next = flip_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start) begin
            run_next  = 1'b1;
            step_next = '0;
            flip_next = fold;
            x_next    = CORDIC_GAIN_Q30;
            y_next    = '0;
            z_next    = $signed({{2{folded[31]}}, folded});
        end else if (run_reg) begin
            if (!z_reg[33]) begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end else begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            step_next = step_reg + 1'b1;
            if (last) begin
                run_next  = 1'b0;
                done_next = 1'b1;
                step_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flip_reg <= flip_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    assign xf = flip_reg ? -x_reg : x_reg;
    assign yf = flip_reg ? -y_reg : y_reg;

    always_comb
    begin
        if (xf > ONE_Q30) begin
            cos_val = 32'sd1073741824;
        end else if (xf < -ONE_Q30) begin
            cos_val = -32'sd1073741824;
        end else begin
            cos_val = xf[31:0];
        end
        if (yf > ONE_Q30) begin
            sin_val = 32'sd1073741824;
        end else if (yf < -ONE_Q30) begin
            sin_val = -32'sd1073741824;
        end else begin
            sin_val = yf[31:0];
        end
    end

    assign busy = run_reg | done_reg;
    assign done = done_reg;

endmodule

### src/ddo_div.sv
// Restoring divider, one quotient bit a cycle, with a 32-bit saturating quotient.
module ddo_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [31:0] den,
    output logic        busy,
    output logic        done,
    output logic [31:0] quot,
    output logic        sat
);
    logic        run_reg, run_next;
    logic        fin_reg, fin_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] den_reg, den_next;
    logic        sat_reg, sat_next;

    logic [32:0] trial;
    logic        ge;

    assign trial = {rem_reg, q_reg[31]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        run_next = run_reg;
        fin_next = 1'b0;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        q_next   = q_reg;
        den_next = den_reg;
        sat_next = sat_reg;
        if (start) begin
            den_next = den;
            cnt_next = '0;
            rem_next = num[63:32];
            q_next   = num[31:0];
            // A high half at or above the divisor means a quotient of 2^32 or more.
            if (num[63:32] >= den) begin
                sat_next = 1'b1;
                fin_next = 1'b1;
            end else begin
                sat_next = 1'b0;
                run_next = 1'b1;
            end
        end else if (run_reg) begin
            rem_next = ge ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
            q_next   = {q_reg[30:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 5'd31) begin
                run_next = 1'b0;
                fin_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            run_reg <= 1'b0;
            fin_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            run_reg <= run_next;
            fin_reg <= fin_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        sat_reg <= sat_next;
    end

    assign busy = run_reg | fin_reg;
    assign done = fin_reg;
    assign quot = q_reg;
    assign sat  = sat_reg;

endmodule

### src/ddo_dp.sv
// Datapath: shared multiplier, CORDIC, divider, pose state and result register.
module ddo_dp #(
    parameter int TIME_TICKS_PER_SECOND = 1000000,
    parameter int CORDIC_STEPS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ddo_pkg::cmd_t       cmd,
    output ddo_pkg::sts_t       sts,
    input  logic [31:0]         meters_per_count,
    input  logic [31:0]         radians_per_count,
    input  logic [31:0]         inverse_track_width,
    input  logic signed [31:0]  left_count,
    input  logic signed [31:0]  right_count,
    input  logic [31:0]         sample_time,
    output logic signed [47:0]  pose_x,
    output logic signed [47:0]  pose_y,
    output logic [31:0]         yaw_angle,
    output logic signed [31:0]  quat_z,
    output logic signed [31:0]  quat_w,
    output logic signed [31:0]  linear_speed,
    output logic signed [31:0]  turn_rate,
    output logic signed [47:0]  left_wheel_angle,
    output logic signed [47:0]  right_wheel_angle,
    output logic                rate_invalid
);
    import ddo_pkg::*;

    localparam logic [31:0] TICKS = 32'(TIME_TICKS_PER_SECOND);

    function automatic logic [31:0] speed_of(input logic [31:0] q, input logic sat,
                                             input logic neg);
        logic [31:0] v;
        begin
            if (!neg) begin
                v = (sat || q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
            end else begin
                v = (sat || q > 32'h8000_0000) ? 32'h8000_0000 : q;
                v = -v;
            end
            return v;
        end
    endfunction

    // Item and step state.
    logic signed [31:0] in_left_reg, in_right_reg;
    logic [31:0]        in_time_reg;
    logic [31:0]        prev_left_reg, prev_right_reg, prev_time_reg;
    logic [31:0]        dt_reg;
    logic [32:0]        sum_mag_reg, diff_mag_reg;
    logic               sum_neg_reg, diff_neg_reg;
    logic [63:0]        cm_reg, rm_reg, vlin_reg, vturn_reg;
    logic [31:0]        dbam_reg, hbam_reg;
    logic signed [31:0] c_reg, s_reg, qw_reg, qz_reg;
    logic signed [47:0] kept_x_reg, kept_y_reg;
    logic [31:0]        heading_reg;
    logic [31:0]        lin_reg, turn_reg;
    logic signed [47:0] lwa_reg, rwa_reg;
    logic               cor_sel_reg, div_sel_reg;

    // Shared multiplier.
    logic [2:0]  mcnt_reg;
    mul_op_t     mop_reg;
    logic [63:0] ma_reg;
    logic [31:0] mb_reg;
    logic [5:0]  msh_reg;
    logic [63:0] mlo_reg, mhi_reg, mres_reg;
    logic [63:0] ma;
    logic [31:0] mb;
    logic [5:0]  msh;
    logic [63:0] lo_prod, hi_prod;
    logic [95:0] prod, shifted;

    // Step differences.
    logic [31:0]        dl_raw, dr_raw;
    logic signed [33:0] sum, diff, sum_abs, diff_abs;
    logic [31:0]        c_mag, s_mag, l_mag, r_mag;
    logic [31:0]        cor_angle, heading_new;
    logic [31:0]        dbam_new, hbam_new;

    logic               cor_done, cor_busy;
    logic signed [31:0] cor_cos, cor_sin;
    logic               div_done, div_busy, div_sat;
    logic [31:0]        div_quot;

    assign dl_raw   = in_left_reg - prev_left_reg;
    assign dr_raw   = in_right_reg - prev_right_reg;
    assign sum      = $signed({{2{dl_raw[31]}}, dl_raw}) + $signed({{2{dr_raw[31]}}, dr_raw});
    assign diff     = $signed({{2{dr_raw[31]}}, dr_raw}) - $signed({{2{dl_raw[31]}}, dl_raw});
    assign sum_abs  = sum[33] ? -sum : sum;
    assign diff_abs = diff[33] ? -diff : diff;

    assign c_mag = c_reg[31] ? 32'(-c_reg) : c_reg;
    assign s_mag = s_reg[31] ? 32'(-s_reg) : s_reg;
    assign l_mag = in_left_reg[31] ? 32'(-in_left_reg) : in_left_reg;
    assign r_mag = in_right_reg[31] ? 32'(-in_right_reg) : in_right_reg;

    assign heading_new = heading_reg + dbam_reg;
    assign cor_angle   = cmd.cor_quat ? (heading_new >> 1) : heading_reg + hbam_reg;

    always_comb
    begin
        unique case (cmd.mul_op)
            MOP_CM:    begin ma = 64'(sum_mag_reg);  mb = meters_per_count;    msh = 6'd1;  end
            MOP_P:     begin ma = 64'(diff_mag_reg); mb = meters_per_count;    msh = 6'd0;  end
            MOP_RM:    begin ma = rm_reg;            mb = inverse_track_width; msh = 6'd24; end
            MOP_BAM:   begin ma = rm_reg;            mb = INV_TWO_PI_Q32;      msh = 6'd32; end
            MOP_VLIN:  begin ma = cm_reg;            mb = TICKS;               msh = 6'd16; end
            MOP_VTURN: begin ma = rm_reg;            mb = TICKS;               msh = 6'd16; end
            MOP_X:     begin ma = cm_reg;            mb = c_mag;               msh = 6'd30; end
            MOP_Y:     begin ma = cm_reg;            mb = s_mag;               msh = 6'd30; end
            MOP_WL:    begin ma = 64'(l_mag);        mb = radians_per_count;   msh = 6'd16; end
            MOP_WR:    begin ma = 64'(r_mag);        mb = radians_per_count;   msh = 6'd16; end
            default:   begin ma = '0;                mb = '0;                  msh = '0;    end
        endcase
    end

    assign lo_prod = ma_reg[31:0] * mb_reg;
    assign hi_prod = ma_reg[63:32] * mb_reg;
    assign prod    = {mhi_reg, 32'b0} + {32'b0, mlo_reg};
    assign shifted = prod >> msh_reg;

    assign dbam_new = diff_neg_reg ? -mres_reg[31:0] : mres_reg[31:0];
    assign hbam_new = diff_neg_reg ? -mres_reg[32:1] : mres_reg[32:1];

    ddo_cordic #(
        .STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.cor_start),
        .angle  (cor_angle),
        .busy   (cor_busy),
        .done   (cor_done),
        .cos_val(cor_cos),
        .sin_val(cor_sin)
    );

    ddo_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cmd.div_start),
        .num  (cmd.div_turn ? vturn_reg : vlin_reg),
        .den  (dt_reg),
        .busy (div_busy),
        .done (div_done),
        .quot (div_quot),
        .sat  (div_sat)
    );

    // Multiplier sequencing: low partial product, high partial product,
    // shift and saturate, then write back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mcnt_reg <= '0;
        end else if (cmd.mul_start) begin
            mcnt_reg <= 3'd1;
        end else if (mcnt_reg == 3'd4) begin
            mcnt_reg <= '0;
        end else if (mcnt_reg != 3'd0) begin
            mcnt_reg <= mcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            prev_time_reg  <= '0;
            kept_x_reg     <= '0;
            kept_y_reg     <= '0;
            heading_reg    <= '0;
        end else begin
            if (cmd.latch) begin
                prev_left_reg  <= in_left_reg;
                prev_right_reg <= in_right_reg;
                prev_time_reg  <= in_time_reg;
            end
            if (mcnt_reg == 3'd4 && mop_reg == MOP_X) begin
                kept_x_reg <= add_pos(kept_x_reg, mres_reg, sum_neg_reg ^ c_reg[31]);
            end
            if (mcnt_reg == 3'd4 && mop_reg == MOP_Y) begin
                kept_y_reg <= add_pos(kept_y_reg, mres_reg, sum_neg_reg ^ s_reg[31]);
            end
            if (cmd.cor_start && cmd.cor_quat) begin
                heading_reg <= heading_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take) begin
            in_left_reg  <= left_count;
            in_right_reg <= right_count;
            in_time_reg  <= sample_time;
        end
        if (cmd.latch) begin
            dt_reg       <= in_time_reg - prev_time_reg;
            sum_mag_reg  <= sum_abs[32:0];
            sum_neg_reg  <= sum[33];
            diff_mag_reg <= diff_abs[32:0];
            diff_neg_reg <= diff[33];
        end
        if (cmd.mul_start) begin
            mop_reg <= cmd.mul_op;
            ma_reg  <= ma;
            mb_reg  <= mb;
            msh_reg <= msh;
        end
        if (mcnt_reg == 3'd1) begin
            mlo_reg <= lo_prod;
        end
        if (mcnt_reg == 3'd2) begin
            mhi_reg <= hi_prod;
        end
        if (mcnt_reg == 3'd3) begin
            mres_reg <= (|shifted[95:64]) ? '1 : shifted[63:0];
        end
        if (mcnt_reg == 3'd4) begin
            unique case (mop_reg)
                MOP_CM:    cm_reg    <= mres_reg;
                MOP_P:     rm_reg    <= mres_reg;
                MOP_RM:    rm_reg    <= mres_reg;
                MOP_BAM:
                begin
                    dbam_reg <= dbam_new;
                    hbam_reg <= hbam_new;
                end
                MOP_VLIN:  vlin_reg  <= mres_reg;
                MOP_VTURN: vturn_reg <= mres_reg;
                MOP_WL:    lwa_reg   <= in_left_reg[31] ? -mres_reg[47:0] : mres_reg[47:0];
                MOP_WR:    rwa_reg   <= in_right_reg[31] ? -mres_reg[47:0] : mres_reg[47:0];
                default:   ;
            endcase
        end
        if (cmd.cor_start) begin
            cor_sel_reg <= cmd.cor_quat;
        end
        if (cor_done) begin
            if (cor_sel_reg) begin
                qw_reg <= cor_cos;
                qz_reg <= cor_sin;
            end else begin
                c_reg <= cor_cos;
                s_reg <= cor_sin;
            end
        end
        if (cmd.div_start) begin
            div_sel_reg <= cmd.div_turn;
        end
        if (div_done) begin
            if (div_sel_reg) begin
                turn_reg <= (dt_reg == 32'd0) ? '0 : speed_of(div_quot, div_sat, diff_neg_reg);
            end else begin
                lin_reg <= (dt_reg == 32'd0) ? '0 : speed_of(div_quot, div_sat, sum_neg_reg);
            end
        end
        if (cmd.out_load) begin
            pose_x            <= kept_x_reg;
            pose_y            <= kept_y_reg;
            yaw_angle         <= heading_reg;
            quat_z            <= qz_reg;
            quat_w            <= qw_reg;
            linear_speed      <= lin_reg;
            turn_rate         <= turn_reg;
            left_wheel_angle  <= lwa_reg;
            right_wheel_angle <= rwa_reg;
            rate_invalid      <= (dt_reg == 32'd0);
        end
    end

    assign sts.mul_busy = (mcnt_reg != 3'd0);
    assign sts.mul_done = (mcnt_reg == 3'd4);
    assign sts.cor_busy = cor_busy;
    assign sts.cor_done = cor_done;
    assign sts.div_busy = div_busy;

endmodule

### src/ddo_ctrl.sv
// Sequencer that steps one item through the shared arithmetic units.
module ddo_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    input  ddo_pkg::sts_t sts,
    output ddo_pkg::cmd_t cmd
);
    import ddo_pkg::*;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_LATCH  = 5'd1;
    localparam logic [4:0] ST_MCM    = 5'd2;
    localparam logic [4:0] ST_MVLIN  = 5'd3;
    localparam logic [4:0] ST_MP     = 5'd4;
    localparam logic [4:0] ST_MRM    = 5'd5;
    localparam logic [4:0] ST_MVTURN = 5'd6;
    localparam logic [4:0] ST_MBAM   = 5'd7;
    localparam logic [4:0] ST_COR1   = 5'd8;
    localparam logic [4:0] ST_DIV2   = 5'd9;
    localparam logic [4:0] ST_MX     = 5'd10;
    localparam logic [4:0] ST_MY     = 5'd11;
    localparam logic [4:0] ST_COR2   = 5'd12;
    localparam logic [4:0] ST_MWL    = 5'd13;
    localparam logic [4:0] ST_MWR    = 5'd14;
    localparam logic [4:0] ST_WAIT   = 5'd15;
    localparam logic [4:0] ST_OUT    = 5'd16;

    logic [4:0] state_reg, state_next;
    logic       launched_reg, launched_next;
    logic       first_reg, first_next;
    logic       out_valid_reg, out_valid_next;

    mul_op_t    step_op;
    logic [4:0] step_after;

    // Operation and successor of each multiplier step.
    always_comb
    begin
        unique case (state_reg)
            ST_MCM:    begin step_op = MOP_CM;    step_after = ST_MVLIN;  end
            ST_MVLIN:  begin step_op = MOP_VLIN;  step_after = ST_MP;     end
            ST_MP:     begin step_op = MOP_P;     step_after = ST_MRM;    end
            ST_MRM:    begin step_op = MOP_RM;    step_after = ST_MVTURN; end
            ST_MVTURN: begin step_op = MOP_VTURN; step_after = ST_MBAM;   end
            ST_MBAM:   begin step_op = MOP_BAM;   step_after = ST_COR1;   end
            ST_MX:     begin step_op = MOP_X;     step_after = ST_MY;     end
            ST_MY:     begin step_op = MOP_Y;     step_after = ST_COR2;   end
            ST_MWL:    begin step_op = MOP_WL;    step_after = ST_MWR;    end
            ST_MWR:    begin step_op = MOP_WR;    step_after = ST_WAIT;   end
            default:   begin step_op = MOP_CM;    step_after = ST_IDLE;   end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        launched_next  = launched_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    cmd.take   = 1'b1;
                    state_next = ST_LATCH;
                end
            end
            ST_LATCH:
            begin
                cmd.latch = 1'b1;
                if (first_reg) begin
                    first_next = 1'b0;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_MCM;
                end
            end
            ST_MCM, ST_MVLIN, ST_MP, ST_MRM, ST_MVTURN, ST_MBAM, ST_MX, ST_MY,
            ST_MWL, ST_MWR:
            begin
                if (!launched_reg) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = step_op;
                    launched_next = 1'b1;
                    // Linear speed division runs alongside the following steps.
                    if (state_reg == ST_MP) begin
                        cmd.div_start = 1'b1;
                    end
                end else if (sts.mul_done) begin
                    launched_next = 1'b0;
                    state_next    = step_after;
                end
            end
            ST_COR1, ST_COR2:
            begin
                if (!launched_reg) begin
                    cmd.cor_start = 1'b1;
                    cmd.cor_quat  = (state_reg == ST_COR2);
                    launched_next = 1'b1;
                end else if (sts.cor_done) begin
                    launched_next = 1'b0;
                    state_next    = (state_reg == ST_COR2) ? ST_MWL : ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                if (!sts.div_busy) begin
                    cmd.div_start = 1'b1;
                    cmd.div_turn  = 1'b1;
                    state_next    = ST_MX;
                end
            end
            ST_WAIT:
            begin
                if (!sts.div_busy) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next    = ST_IDLE;
                launched_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            launched_reg  <= 1'b0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            launched_reg  <= launched_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### src/differential_drive_odometry.sv
// Top level of the differential-drive wheel odometry block.
// Each transfer on the input channel carries absolute left and right encoder
// counts and a timestamp; the block answers with one result transfer holding
// the pose (x, y, heading as a binary angle), the yaw quaternion, the linear and
// turn speeds and the absolute wheel angles. The first transfer after reset
// only records the counts and time and yields no result. Each item passes
// through one latch step, ten operations on the one shared 32x32 multiplier,
// two passes of the iterative CORDIC, and one step each to launch the turn
// division, to confirm it has finished and to load the result; the speed
// divisions run alongside the other steps and, at the default of 24 steps,
// add no time. The next input transfer can be accepted in the cycle after
// the result is loaded. The input is stalled while an item is being worked
// on, but a finished result held in the output register does not block the
// next input transfer; only when a new result is ready while the previous
// one is still stalled does the block wait for the output side before it
// returns to accepting input. Speeds read zero with rate_invalid set when the
// elapsed time is zero, and saturate otherwise. The user must write the three
// scale registers through the configuration port only while the block is
// idle; the block itself does not enforce this.
module differential_drive_odometry #(
    parameter int TIME_TICKS_PER_SECOND = 1000000,
    parameter int CORDIC_STEPS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] left_count,
    input  logic signed [31:0] right_count,
    input  logic [31:0]        sample_time,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [47:0] pose_x,
    output logic signed [47:0] pose_y,
    output logic [31:0]        yaw_angle,
    output logic signed [31:0] quat_z,
    output logic signed [31:0] quat_w,
    output logic signed [31:0] linear_speed,
    output logic signed [31:0] turn_rate,
    output logic signed [47:0] left_wheel_angle,
    output logic signed [47:0] right_wheel_angle,
    output logic               rate_invalid
);
    import ddo_pkg::*;

    // Scale registers: meters and radians per count (Q0.32) and the inverse
    // track width (Q8.24). Writes to an unused index are ignored.
    logic [31:0] meters_reg, radians_reg, inv_track_reg;

    cmd_t cmd;
    sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            meters_reg    <= METERS_RESET;
            radians_reg   <= RADIANS_RESET;
            inv_track_reg <= INV_TRACK_RESET;
        end else if (cfg_write) begin
            if (cfg_index == CFG_METERS) begin
                meters_reg <= cfg_data;
            end
            if (cfg_index == CFG_RADIANS) begin
                radians_reg <= cfg_data;
            end
            if (cfg_index == CFG_INV_TRACK) begin
                inv_track_reg <= cfg_data;
            end
        end
    end

    // The controller walks each item through the steps; the datapath owns all
    // arithmetic, the running pose and the output register.
    ddo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ddo_dp #(
        .TIME_TICKS_PER_SECOND(TIME_TICKS_PER_SECOND),
        .CORDIC_STEPS         (CORDIC_STEPS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .meters_per_count   (meters_reg),
        .radians_per_count  (radians_reg),
        .inverse_track_width(inv_track_reg),
        .left_count         (left_count),
        .right_count        (right_count),
        .sample_time        (sample_time),
        .pose_x             (pose_x),
        .pose_y             (pose_y),
        .yaw_angle          (yaw_angle),
        .quat_z             (quat_z),
        .quat_w             (quat_w),
        .linear_speed       (linear_speed),
        .turn_rate          (turn_rate),
        .left_wheel_angle   (left_wheel_angle),
        .right_wheel_angle  (right_wheel_angle),
        .rate_invalid       (rate_invalid)
    );

    // The shared multiplier is never relaunched while an operation is in flight.
    a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start |-> !sts.mul_busy)
        else $error("multiplier launched while busy");

    // A division never starts over one that has not delivered its quotient.
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider launched while busy");

    // The CORDIC starts only once its angle operands are settled.
    a_cor_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cor_start |-> !sts.cor_busy && !sts.mul_busy)
        else $error("CORDIC launched while units busy");

    // A result is loaded only after every unit has finished with the item.
    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !sts.div_busy && !sts.mul_busy && !sts.cor_busy)
        else $error("result loaded before the item finished");

endmodule

### sim/differential_drive_odometry_tb.sv
// Self-checking testbench for the differential-drive wheel odometry block.
`timescale 1ns / 1ps

module differential_drive_odometry_tb;
    import ddo_pkg::*;

    localparam int TICKS_PER_SECOND = 1000000;
    localparam int ROTATION_STEPS = 24;
    // Worst case from an accepted transfer to its result, with some margin.
    localparam int SETTLE_CYCLES = 200;

    // One expected or observed result transfer.
    typedef struct {
        logic signed [47:0] x;
        logic signed [47:0] y;
        logic [31:0]        yaw;
        logic signed [31:0] qz;
        logic signed [31:0] qw;
        logic signed [31:0] lin;
        logic signed [31:0] turn;
        logic signed [47:0] wl;
        logic signed [47:0] wr;
        logic               inval;
    } pose_report_t;

    // Tracks the pose the block should report and checks each result against it.
    class odometry_scoreboard;
        logic [31:0] meters_scale;
        logic [31:0] radians_scale;
        logic [31:0] inv_track;
        bit          first_pending;
        logic [31:0] last_left;
        logic [31:0] last_right;
        logic [31:0] last_time;
        longint      pos_x;
        longint      pos_y;
        logic [31:0] heading;
        pose_report_t pending_poses[$];
        int          mismatches;

        function new();
            meters_scale = METERS_RESET;
            radians_scale = RADIANS_RESET;
            inv_track = INV_TRACK_RESET;
            first_pending = 1;
            last_left = 0;
            last_right = 0;
            last_time = 0;
            pos_x = 0;
            pos_y = 0;
            heading = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            if (idx == CFG_METERS)
                meters_scale = value;
            else if (idx == CFG_RADIANS)
                radians_scale = value;
            else if (idx == CFG_INV_TRACK)
                inv_track = value;
        endfunction

        // Unsigned (a * b) >> sh, saturated to 64 bits.
        function logic [63:0] scale_shift(logic [63:0] a, logic [31:0] b, int sh);
            logic [127:0] prod;
            logic [127:0] shifted;
            prod = {64'd0, a} * {96'd0, b};
            shifted = prod >> sh;
            if (shifted[127:64] != 0)
                return '1;
            return shifted[63:0];
        endfunction

        function logic [63:0] magnitude(longint v);
            return v < 0 ? 64'(-v) : 64'(v);
        endfunction

        // Cosine and sine of a binary angle, iterative rotation in Q1.30.
        function void rotate(logic [31:0] ang, output longint c, output longint s);
            logic [31:0] arctan [32] = '{
                536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                81, 41, 20, 10, 5, 3, 1, 1, 0};
            bit     flip;
            longint cx;
            longint cy;
            longint cz;
            longint dx;
            longint dy;
            flip = 0;
            cx = 652032874;
            cy = 0;
            // Fold the angle into the right half plane and mirror afterward.
            if (ang > 32'h4000_0000 && ang < 32'hC000_0000) begin
                ang = ang + 32'h8000_0000;
                flip = 1;
            end
            cz = longint'($signed(ang));
            for (int i = 0; i < ROTATION_STEPS && i < 32; i++) begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (cz >= 0) begin
                    cx -= dx;
                    cy += dy;
                    cz -= longint'(arctan[i]);
                end else begin
                    cx += dx;
                    cy -= dy;
                    cz += longint'(arctan[i]);
                end
            end
            if (flip) begin
                cx = -cx;
                cy = -cy;
            end
            c = cx > 1073741824 ? 1073741824 : (cx < -1073741824 ? -1073741824 : cx);
            s = cy > 1073741824 ? 1073741824 : (cy < -1073741824 ? -1073741824 : cy);
        endfunction

        function longint advance(longint base, logic [63:0] m, bit neg);
            longint stepv;
            longint sum;
            if (m > 64'h0001_0000_0000_0000)
                m = 64'h0001_0000_0000_0000;
            stepv = neg ? -longint'(m) : longint'(m);
            sum = base + stepv;
            if (sum > 64'sh7FFF_FFFF_FFFF)
                sum = 64'sh7FFF_FFFF_FFFF;
            if (sum < -64'sh8000_0000_0000)
                sum = -64'sh8000_0000_0000;
            return sum;
        endfunction

        function logic [31:0] rate_of(logic [63:0] m, bit neg, logic [31:0] dt);
            logic [63:0] v;
            v = scale_shift(m, TICKS_PER_SECOND, 16) / {32'd0, dt};
            if (neg) begin
                if (v > 64'h8000_0000)
                    v = 64'h8000_0000;
                return 32'(-v);
            end
            if (v > 64'h7FFF_FFFF)
                v = 64'h7FFF_FFFF;
            return v[31:0];
        endfunction

        function logic [47:0] wheel_angle(logic [31:0] cnt);
            longint      c;
            logic [63:0] m;
            c = longint'($signed(cnt));
            m = scale_shift(magnitude(c), radians_scale, 16);
            return c < 0 ? 48'(-m) : m[47:0];
        endfunction

        // Advances the predicted pose for one accepted input transfer; the first one after reset is only recorded.
        function void note_input(logic [31:0] lc, logic [31:0] rc, logic [31:0] tm);
            pose_report_t p;
            logic [31:0]  dt;
            logic [31:0]  dbam;
            logic [31:0]  hbam;
            logic [63:0]  cm;
            logic [63:0]  rm;
            logic [63:0]  bm;
            longint       dl;
            longint       dr;
            longint       sum;
            longint       diff;
            longint       c;
            longint       s;
            longint       qw;
            longint       qz;
            bit           cneg;
            bit           dneg;
            if (first_pending) begin
                last_left = lc;
                last_right = rc;
                last_time = tm;
                first_pending = 0;
                return;
            end
            dt = tm - last_time;
            dl = longint'($signed(lc - last_left));
            dr = longint'($signed(rc - last_right));
            last_left = lc;
            last_right = rc;
            last_time = tm;

            sum = dl + dr;
            cneg = sum < 0;
            cm = scale_shift(magnitude(sum), meters_scale, 1);
            diff = dr - dl;
            dneg = diff < 0;
            rm = scale_shift(scale_shift(magnitude(diff), meters_scale, 0), inv_track, 24);
            bm = scale_shift(rm, INV_TWO_PI_Q32, 32);
            dbam = bm[31:0];
            hbam = bm[32:1];
            if (dneg) begin
                dbam = -dbam;
                hbam = -hbam;
            end

            // Step along the heading halfway through the turn.
            rotate(heading + hbam, c, s);
            pos_x = advance(pos_x, scale_shift(cm, 32'(magnitude(c)), 30), cneg != (c < 0));
            pos_y = advance(pos_y, scale_shift(cm, 32'(magnitude(s)), 30), cneg != (s < 0));
            heading = heading + dbam;
            rotate(heading >> 1, qw, qz);

            p.x = pos_x[47:0];
            p.y = pos_y[47:0];
            p.yaw = heading;
            p.qz = qz[31:0];
            p.qw = qw[31:0];
            if (dt == 0) begin
                p.lin = 0;
                p.turn = 0;
                p.inval = 1;
            end else begin
                p.lin = rate_of(cm, cneg, dt);
                p.turn = rate_of(rm, dneg, dt);
                p.inval = 0;
            end
            p.wl = wheel_angle(lc);
            p.wr = wheel_angle(rc);
            pending_poses.push_back(p);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
            mismatches++;
        endtask

        task compare(string what, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report(what, got, want);
        endtask

        task check_result(pose_report_t got);
            pose_report_t want;
            if (pending_poses.size() == 0) begin
                report("unexpected result", 0, 0);
                return;
            end
            want = pending_poses.pop_front();
            compare("pose_x", 64'(got.x), 64'(want.x));
            compare("pose_y", 64'(got.y), 64'(want.y));
            compare("yaw_angle", 64'(got.yaw), 64'(want.yaw));
            compare("quat_z", 64'(got.qz), 64'(want.qz));
            compare("quat_w", 64'(got.qw), 64'(want.qw));
            compare("linear_speed", 64'(got.lin), 64'(want.lin));
            compare("turn_rate", 64'(got.turn), 64'(want.turn));
            compare("left_wheel_angle", 64'(got.wl), 64'(want.wl));
            compare("right_wheel_angle", 64'(got.wr), 64'(want.wr));
            compare("rate_invalid", 64'(got.inval), 64'(want.inval));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic [31:0]        sample_time;
    logic               out_valid;
    logic               out_stall;
    logic signed [47:0] pose_x;
    logic signed [47:0] pose_y;
    logic [31:0]        yaw_angle;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] linear_speed;
    logic signed [31:0] turn_rate;
    logic signed [47:0] left_wheel_angle;
    logic signed [47:0] right_wheel_angle;
    logic               rate_invalid;

    odometry_scoreboard odo_sb;
    // While set, neither side inserts gaps or stalls.
    bit                 steady_flow;
    // Running encoder and time values for the well-formed random motion.
    logic [31:0]        enc_left;
    logic [31:0]        enc_right;
    logic [31:0]        clock_ticks;

    differential_drive_odometry #(
        .TIME_TICKS_PER_SECOND(TICKS_PER_SECOND),
        .CORDIC_STEPS(ROTATION_STEPS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .left_count(left_count),
        .right_count(right_count),
        .sample_time(sample_time),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .pose_x(pose_x),
        .pose_y(pose_y),
        .yaw_angle(yaw_angle),
        .quat_z(quat_z),
        .quat_w(quat_w),
        .linear_speed(linear_speed),
        .turn_rate(turn_rate),
        .left_wheel_angle(left_wheel_angle),
        .right_wheel_angle(right_wheel_angle),
        .rate_invalid(rate_invalid)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Generous overall limit; a correct run finishes far sooner.
    initial
    begin
        #10ms;
        $display("Some tests failed");
        $finish;
    end

    // Result side: stalls at random on the falling edge and checks each
    // transfer on the rising edge.
    initial
    begin
        pose_report_t got;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                got.x = pose_x;
                got.y = pose_y;
                got.yaw = yaw_angle;
                got.qz = quat_z;
                got.qw = quat_w;
                got.lin = linear_speed;
                got.turn = turn_rate;
                got.wl = left_wheel_angle;
                got.wr = right_wheel_angle;
                got.inval = rate_invalid;
                odo_sb.check_result(got);
            end
            @(negedge clk);
            out_stall <= !steady_flow && ($urandom_range(0, 99) < 18);
        end
    end

    // Presents one transfer, with a random gap in front, and holds it until
    // the block accepts it. The payload is noted with the predictor on acceptance.
    task send_sample(logic [31:0] lc, logic [31:0] rc, logic [31:0] tm);
        bit accepted;
        @(negedge clk);
        while (!steady_flow && $urandom_range(0, 99) < 18) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        left_count <= lc;
        right_count <= rc;
        sample_time <= tm;
        accepted = 0;
        while (!accepted) begin
            @(posedge clk);
            accepted = !in_stall;
            if (!accepted)
                @(negedge clk);
        end
        odo_sb.note_input(lc, rc, tm);
        enc_left = lc;
        enc_right = rc;
        clock_ticks = tm;
    endtask

    task release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Waits until every predicted result has come, then lets the block settle.
    task drain();
        release_input();
        while (odo_sb.pending_poses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        odo_sb.write_reg(idx, value);
    endtask

    task load_scales(logic [31:0] meters, logic [31:0] radians, logic [31:0] inv_track);
        drain();
        write_reg(CFG_METERS, meters);
        write_reg(CFG_RADIANS, radians);
        write_reg(CFG_INV_TRACK, inv_track);
    endtask

    // Extremes of the counts and time: wrap of counts, time wrap, zero elapsed
    // time, sharp turns both ways and one tick of elapsed time.
    task send_corner_cases();
        send_sample(32'd0, 32'd0, 32'd0);
        send_sample(32'd100, 32'd100, 32'd1000);
        send_sample(32'd100, 32'd100, 32'd1000);
        send_sample(-32'sd50, 32'd250, 32'd2000);
        send_sample(32'd300, -32'sd400, 32'd2500);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'd2501);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'd2501);
        send_sample(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        send_sample(32'h0000_0001, 32'hFFFF_FFFF, 32'd4);
        send_sample(32'h4000_0000, 32'h4000_0000, 32'd5);
        send_sample(32'h0000_0000, 32'h0000_0000, 32'd6);
        send_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0006);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0006);
        send_sample(32'd5000, 32'd9000, 32'h8001_0000);
        send_sample(32'd9000, 32'd5000, 32'h8002_0000);
    endtask

    // Mostly smooth motion with small count steps; now and then a raw random
    // transfer, a repeated time stamp or a sharp jump.
    task send_random(int count, bit with_pause);
        logic [31:0] lc;
        logic [31:0] rc;
        logic [31:0] tm;
        int          pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            lc = enc_left + 32'($urandom_range(0, 800)) - 32'd400;
            rc = enc_right + 32'($urandom_range(0, 800)) - 32'd400;
            tm = clock_ticks + 32'($urandom_range(1, 60000));
            if (pick < 8) begin
                lc = $urandom;
                rc = $urandom;
                tm = $urandom;
            end else if (pick < 14) begin
                tm = clock_ticks;
            end else if (pick < 20) begin
                rc = enc_right + $urandom;
                tm = clock_ticks + 32'($urandom_range(1, 4));
            end
            // Hold off now and then until the block has answered everything.
            if (with_pause && n % 97 == 50) begin
                release_input();
                while (odo_sb.pending_poses.size() != 0)
                    @(posedge clk);
            end
            send_sample(lc, rc, tm);
        end
    endtask

    initial
    begin
        odo_sb = new();
        steady_flow = 0;
        enc_left = 0;
        enc_right = 0;
        clock_ticks = 0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_METERS;
        cfg_data = '0;
        in_valid = 1'b0;
        left_count = '0;
        right_count = '0;
        sample_time = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Default scales: corner cases, then random motion with a gap-free stretch.
        send_corner_cases();
        send_random(150, 1);
        steady_flow = 1;
        send_random(100, 0);
        steady_flow = 0;

        // Largest scales drive the position and speeds into saturation.
        load_scales(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_corner_cases();
        send_random(80, 0);

        // Zero scales freeze the pose.
        load_scales(32'd0, 32'd0, 32'd0);
        send_random(40, 0);

        // A few random settings.
        for (int k = 0; k < 4; k++) begin
            load_scales($urandom, $urandom, $urandom);
            send_random(80, k == 0);
        end

        load_scales(METERS_RESET, RADIANS_RESET, INV_TRACK_RESET);
        send_random(60, 0);

        drain();
        if (odo_sb.pending_poses.size() != 0)
            odo_sb.report("results never arrived", 64'(odo_sb.pending_poses.size()), 0);
        if (odo_sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
src/ddo_pkg.sv
src/ddo_cordic.sv
src/ddo_div.sv
src/ddo_dp.sv
src/ddo_ctrl.sv
src/differential_drive_odometry.sv
sim/differential_drive_odometry_tb.sv
